FILE: design/wcrc_pkg.sv
// Shared types, constants and constant functions for the 32-bit word CRC checksum.
// The 32-bit shift update is linear, so it is folded into constant row masks here.
// No dependencies.
`default_nettype none

package wcrc_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned CountW   = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw  = $clog2(QueueDepth);

  localparam logic [WordW-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] CrcPoly = 32'h0456_3521;

  typedef logic [WordW-1:0][WordW-1:0] row_masks_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             has_data;
    logic             first;
    logic             last;
  } wcrc_item_t;

  // Bit-serial reference update; only evaluated on constants at elaboration.
  function automatic logic [WordW-1:0] shift_word(input logic [WordW-1:0] rem_in,
                                                  input logic [WordW-1:0] word_in);
    logic [WordW-1:0] rem_v;
    logic [WordW-1:0] word_v;
    logic             carry;
    rem_v  = rem_in;
    word_v = word_in;
    for (int k = 0; k < WordW; k++) begin
      carry  = rem_v[WordW-1];
      rem_v  = {rem_v[WordW-2:0], word_v[WordW-1]};
      word_v = {word_v[WordW-2:0], 1'b0};
      if (carry) begin
        rem_v = rem_v ^ CrcPoly;
      end
    end
    return rem_v;
  endfunction

  // Row i holds the remainder bits that feed output bit i.
  function automatic row_masks_t rem_rows();
    row_masks_t       rows;
    logic [WordW-1:0] col;
    rows = '0;
    for (int j = 0; j < WordW; j++) begin
      col = shift_word(WordW'(1) << j, '0);
      for (int i = 0; i < WordW; i++) begin
        rows[i][j] = col[i];
      end
    end
    return rows;
  endfunction

  // Row i holds the data bits that feed output bit i.
  function automatic row_masks_t word_rows();
    row_masks_t       rows;
    logic [WordW-1:0] col;
    rows = '0;
    for (int j = 0; j < WordW; j++) begin
      col = shift_word('0, WordW'(1) << j);
      for (int i = 0; i < WordW; i++) begin
        rows[i][j] = col[i];
      end
    end
    return rows;
  endfunction

  localparam row_masks_t RemRows  = rem_rows();
  localparam row_masks_t WordRows = word_rows();

  // One parity per output bit; the bits are independent.
  function automatic logic [WordW-1:0] apply_rows(input row_masks_t rows,
                                                  input logic [WordW-1:0] vec);
    logic [WordW-1:0] res;
    for (int i = 0; i < WordW; i++) begin
      res[i] = ^(rows[i] & vec);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/word_crc32_checksum.sv
// Top level of the word 32-bit CRC checksum: front end, item queue, back end.
// Depends on wcrc_pkg, wcrc_front, wcrc_queue and wcrc_back.
//
// Takes one item per cycle while not stalled. Each item carries up to four bytes,
// first byte in bits 7:0; first reloads the remainder with all ones, last appends
// 32 zero bits and returns the checksum. A two-entry queue separates the input
// from the remainder update. A stalled checksum output holds a last item at the
// head of the queue, and the input stalls only once the queue behind it fills.
// With an empty queue, an accepted item's data reaches the remainder at the edge
// that pops it from the queue. The checksum of a last item is registered at
// that same edge and can be taken at the next edge at the earliest.
// The sustained rate of one item per cycle, while nothing stalls, comes from the
// remainder update, which folds all 32 bit steps (and the flush) into XOR trees.
`default_nettype none

module word_crc32_checksum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wcrc_pkg::WordW-1:0]  data_word,
  input  logic [wcrc_pkg::CountW-1:0] byte_count,
  input  logic                        first,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wcrc_pkg::WordW-1:0]  checksum
);
  import wcrc_pkg::*;

  wcrc_item_t front_item;
  wcrc_item_t q_head;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;

  assign in_ready = !q_full;

  wcrc_front u_front (
    .data_word  (data_word),
    .byte_count (byte_count),
    .first      (first),
    .last       (last),
    .item       (front_item)
  );

  wcrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  wcrc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .checksum    (checksum)
  );

endmodule

`default_nettype wire

FILE: design/wcrc_front.sv
// Front end: masks the data word to its valid bytes and classifies the item.
// Depends on wcrc_pkg.
`default_nettype none

module wcrc_front (
  input  logic [wcrc_pkg::WordW-1:0]  data_word,
  input  logic [wcrc_pkg::CountW-1:0] byte_count,
  input  logic                        first,
  input  logic                        last,
  output wcrc_pkg::wcrc_item_t        item
);
  import wcrc_pkg::*;

  logic [WordW-1:0] mask;

  always_comb begin
    case (byte_count) inside
      3'd0:          mask = 32'h0000_0000;
      3'd1:          mask = 32'h0000_00FF;
      3'd2:          mask = 32'h0000_FFFF;
      3'd3:          mask = 32'h00FF_FFFF;
      [3'd4:3'd7]:   mask = 32'hFFFF_FFFF;
      default:       mask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    item.word     = data_word & mask;
    item.has_data = (byte_count != '0);
    item.first    = first;
    item.last     = last;
  end

endmodule

`default_nettype wire

FILE: design/wcrc_queue.sv
// Short item queue between front and back end.
// Depends on wcrc_pkg.
`default_nettype none

module wcrc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wcrc_pkg::wcrc_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output wcrc_pkg::wcrc_item_t head
);
  import wcrc_pkg::*;

  wcrc_item_t           mem [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr;
  logic [QueueAw-1:0]   rd_ptr;
  logic [QueueAw:0]     count;

  assign full      = (count == (QueueAw+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueueAw'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueueAw'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/wcrc_back.sv
// Back end: holds the running remainder, applies data and flush updates,
// and drives the checksum output register. Depends on wcrc_pkg.
`default_nettype none

module wcrc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_not_empty,
  input  wcrc_pkg::wcrc_item_t       q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [wcrc_pkg::WordW-1:0] checksum
);
  import wcrc_pkg::*;

  logic [WordW-1:0] remainder;
  logic [WordW-1:0] remainder_next;
  logic [WordW-1:0] base;
  logic [WordW-1:0] upd;
  logic [WordW-1:0] flushed;

  assign q_pop = q_not_empty && (!q_head.last || !out_valid || out_ready);

  always_comb begin
    base    = q_head.first ? CrcInit : remainder;
    upd     = q_head.has_data ? (apply_rows(RemRows, base) ^ apply_rows(WordRows, q_head.word))
                              : base;
    flushed = apply_rows(RemRows, upd);
    remainder_next = q_head.last ? flushed : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= CrcInit;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        remainder <= remainder_next;
      end
      if (q_pop && q_head.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      checksum <= flushed;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for word_crc32_checksum: directed items, random messages,
// output back-pressure and drain phases, each checksum compared against a local model.
// Depends on wcrc_pkg and the word_crc32_checksum RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WW = wcrc_pkg::WordW;
  localparam int unsigned CW = wcrc_pkg::CountW;
  localparam logic [WW-1:0] SEED_VALUE = 32'hFFFF_FFFF;
  localparam logic [WW-1:0] GEN_POLY = 32'h0456_3521;
  localparam int unsigned TOTAL_ITEMS = 950;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WW-1:0] data_word = '0;
  logic [CW-1:0] byte_count = '0;
  logic first = 1'b0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WW-1:0] checksum;

  logic [WW-1:0] crc_state = SEED_VALUE;
  logic [WW-1:0] pending_sums[$];
  int unsigned items_sent = 0;
  int unsigned sums_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_left = 0;
  bit rx_stalling = 1'b0;
  bit rx_pacing_on = 1'b0;

  word_crc32_checksum dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_word(data_word),
    .byte_count(byte_count),
    .first(first),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .checksum(checksum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%t: timeout after %0d cycles", $time, cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Bit-serial long division, MSB of the word first.
  function automatic logic [WW-1:0] crc_shift(logic [WW-1:0] rem, logic [WW-1:0] word);
    logic carry;
    for (int b = WW - 1; b >= 0; b--) begin
      carry = rem[WW-1];
      rem = {rem[WW-2:0], word[b]};
      if (carry) begin
        rem = rem ^ GEN_POLY;
      end
    end
    return rem;
  endfunction

  task automatic predict_item(logic [WW-1:0] word, logic [CW-1:0] count,
                              logic is_first, logic is_last);
    int unsigned nbytes;
    logic [WW-1:0] mask;
    nbytes = (count > 4) ? 4 : count;
    mask = (nbytes == 4) ? '1 : ((WW'(1) << (8 * nbytes)) - 1);
    if (is_first) begin
      crc_state = SEED_VALUE;
    end
    if (nbytes != 0) begin
      crc_state = crc_shift(crc_state, word & mask);
    end
    if (is_last) begin
      crc_state = crc_shift(crc_state, '0);
      pending_sums.push_back(crc_state);
    end
  endtask

  // Called in the time step of a rising edge; returns in the step of the accepting edge.
  task automatic send_item(logic [WW-1:0] word, logic [CW-1:0] count,
                           logic is_first, logic is_last);
    in_valid <= 1'b1;
    data_word <= word;
    byte_count <= count;
    first <= is_first;
    last <= is_last;
    do @(negedge clk); while (!in_ready);
    predict_item(word, count, is_first, is_last);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic idle(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_sums.size() != 0);
  endtask

  always @(negedge clk) begin : check_sums
    logic [WW-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        $display("%t: unexpected checksum %h, none expected", $time, checksum);
        mismatches++;
      end else begin
        want = pending_sums.pop_front();
        sums_checked++;
        if (checksum !== want) begin
          $display("%t: checksum mismatch: expected %h, actual %h", $time, want, checksum);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : rx_pacing
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!rx_pacing_on) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_stalling = !rx_stalling;
        rx_left = rx_stalling ? $urandom_range(1, 12) : $urandom_range(1, 16);
      end else begin
        rx_left--;
      end
      out_ready <= !rx_stalling;
    end
  end

  task automatic test_special_cases();
    send_item(32'h1234_5678, 3'd0, 1'b0, 1'b1);  // flush of the reset value
    send_item(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1);
    send_item(32'h0000_0000, 3'd4, 1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd3, 1'b1, 1'b1);
    send_item(32'hA5A5_A5A5, 3'd5, 1'b1, 1'b1);
    send_item(32'h5A5A_5A5A, 3'd6, 1'b1, 1'b1);
    send_item(32'hDEAD_BEEF, 3'd7, 1'b1, 1'b1);
    send_item(32'hCAFE_F00D, 3'd0, 1'b1, 1'b0);
    send_item(32'h0102_0304, 3'd4, 1'b0, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd0, 1'b0, 1'b1);
    send_item(32'h8000_0001, 3'd4, 1'b0, 1'b1);  // continues from flushed value
    send_item(32'hBEEF_0055, 3'd2, 1'b1, 1'b0);
    send_item(32'h7766_5544, 3'd3, 1'b0, 1'b1);
    send_item(32'h0000_0000, 3'd0, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_holdoff();
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      send_item($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b1);
    end
    wait_drained();
  endtask

  task automatic test_random_messages();
    int unsigned msg_len;
    int unsigned burst_left;
    logic [CW-1:0] count;
    burst_left = 0;
    rx_pacing_on = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      if ((items_sent / 150) % 3 == 2) begin
        rx_pacing_on = 1'b0;
      end else begin
        rx_pacing_on = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        msg_len = 1;
        count = 3'($urandom_range(0, 7));
        if (burst_left == 0) begin
          idle($urandom_range(1, 8));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item($urandom, count, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        msg_len = $urandom_range(1, 8);
        for (int i = 0; i < msg_len; i++) begin
          count = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
          if (burst_left == 0) begin
            idle($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
          end
          burst_left--;
          send_item($urandom, count, i == 0, i == msg_len - 1);
        end
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_output_holdoff();
    test_random_messages();
    repeat (10) @(posedge clk);
    $display("Sent %0d items and compared %0d checksums, with byte counts 0..7,",
             items_sent, sums_checked);
    $display("reload and flush corner cases, output hold-off and input drain phases.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: files.f
design/wcrc_pkg.sv
design/wcrc_front.sv
design/wcrc_queue.sv
design/wcrc_back.sv
design/word_crc32_checksum.sv
verif/tb.sv
